@@ rtl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: shared definitions
// Operation codes, cell commands, controller states and field widths.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_STATUS = 3'd0,
    OP_PUSH   = 3'd1,
    OP_POP    = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP,
    CMD_CLEAR,
    CMD_CMP,
    CMD_SCAN
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } ctrl_state_e;

  // Command broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_cmd_e         cmd;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ rtl/bss_cell.sv @@
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shifting stack: a word, an occupied flag and a match flag.
// ----------------------------------------------------------------------------
module bss_cell
  import bss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] prev_data_i,
  input  logic              prev_valid_i,
  input  logic              prev_hit_i,
  input  logic [DATA_W-1:0] next_data_i,
  input  logic              next_valid_i,
  output logic [DATA_W-1:0] data_o,
  output logic              valid_o,
  output logic              hit_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;
  logic              hit_q, hit_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    hit_d   = hit_q;
    case (ctrl_i.cmd)
      CMD_PUSH: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      CMD_POP: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      CMD_CLEAR: valid_d = 1'b0;
      CMD_CMP:   hit_d = valid_q && (data_q == ctrl_i.key);
      CMD_SCAN:  hit_d = prev_hit_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/bss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stack controller
// Decodes operations, tracks the count and bottom word, runs the search scan
// and holds the result register.
// ----------------------------------------------------------------------------
module bss_ctrl
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     capacity_we_i,
  input  logic [CNT_W-1:0]         capacity_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  output cell_ctrl_t               cell_ctrl_o,
  input  logic [DATA_W-1:0]        top_data_i,
  input  logic                     last_hit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     accepted_o,
  output logic                     found_o,
  output logic [IDX_W-1:0]         found_index_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] bottom_value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     full_res_o,
  output logic                     empty_res_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = $clog2(DEPTH);
  localparam int unsigned XW = (CW > CNT_W) ? CW : CNT_W;

  ctrl_state_e state_q, state_d;

  logic [CNT_W-1:0]  cap_q;
  logic [CW-1:0]     count_q;
  logic [DATA_W-1:0] bottom_q;
  logic [KW-1:0]     k_q;
  logic              acc_q, found_q;
  logic [IDX_W-1:0]  fidx_q;

  logic              out_valid_q;
  logic              out_acc_q, out_found_q, out_full_q, out_empty_q;
  logic [IDX_W-1:0]  out_fidx_q;
  logic [DATA_W-1:0] out_top_q, out_bottom_q;
  logic [CNT_W-1:0]  out_count_q;

  logic          take, slot_free, can_push, scan_last, count_zero;
  logic [XW-1:0] cap_ext, cap_eff, count_ext;
  logic [CW:0]   fidx_full;
  op_e           op;

  assign op         = op_e'(operation_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign scan_last  = (k_q == KW'(DEPTH - 1));
  assign count_zero = (count_q == '0);

  // Capacity outside 1..DEPTH is clamped into that range.
  always_comb begin
    cap_ext = XW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = XW'(1);
    end else if (cap_ext > XW'(DEPTH)) begin
      cap_eff = XW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign count_ext = XW'(count_q);
  assign can_push  = (count_ext < cap_eff);

  // The scan moves match flags toward the deepest cell; after k shifts that
  // cell shows the original cell DEPTH-1-k, which sits k+count-DEPTH from the
  // bottom.
  assign fidx_full = (CW+1)'(k_q) + (CW+1)'(count_q) - (CW+1)'(DEPTH);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = (op == OP_FIND) ? S_SCAN : S_REPORT;
        end
      end
      S_SCAN: begin
        if (last_hit_i || scan_last) begin
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Cell commands.
  always_comb begin
    cell_ctrl_o.cmd = CMD_HOLD;
    cell_ctrl_o.key = value_i;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (op)
            OP_PUSH:  cell_ctrl_o.cmd = can_push ? CMD_PUSH : CMD_HOLD;
            OP_POP:   cell_ctrl_o.cmd = count_zero ? CMD_HOLD : CMD_POP;
            OP_FIND:  cell_ctrl_o.cmd = CMD_CMP;
            OP_CLEAR: cell_ctrl_o.cmd = CMD_CLEAR;
            default:  cell_ctrl_o.cmd = CMD_HOLD;
          endcase
        end
      end
      S_SCAN:  cell_ctrl_o.cmd = CMD_SCAN;
      default: cell_ctrl_o.cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
      if (take) begin
        case (op)
          OP_PUSH:  if (can_push) count_q <= count_q + CW'(1);
          OP_POP:   if (!count_zero) count_q <= count_q - CW'(1);
          OP_CLEAR: count_q <= '0;
          default: ;
        endcase
      end
      if (state_q == S_REPORT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      k_q     <= '0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      case (op)
        OP_STATUS, OP_FIND, OP_CLEAR: acc_q <= 1'b1;
        OP_PUSH: begin
          acc_q <= can_push;
          if (can_push && count_zero) begin
            bottom_q <= value_i;
          end
        end
        OP_POP:  acc_q <= !count_zero;
        default: acc_q <= 1'b0;
      endcase
    end else if (state_q == S_SCAN) begin
      if (last_hit_i) begin
        found_q <= 1'b1;
        fidx_q  <= IDX_W'(fidx_full);
      end else begin
        k_q <= k_q + KW'(1);
      end
    end

    if (state_q == S_REPORT && slot_free) begin
      out_acc_q    <= acc_q;
      out_found_q  <= found_q;
      out_fidx_q   <= fidx_q;
      out_top_q    <= count_zero ? '1 : top_data_i;
      out_bottom_q <= count_zero ? '1 : bottom_q;
      out_count_q  <= CNT_W'(count_q);
      out_full_q   <= (count_ext >= cap_eff);
      out_empty_q  <= count_zero;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign found_o        = out_found_q;
  assign found_index_o  = out_fidx_q;
  assign top_value_o    = out_top_q;
  assign bottom_value_o = out_bottom_q;
  assign count_o        = out_count_q;
  assign full_res_o     = out_full_q;
  assign empty_res_o    = out_empty_q;

endmodule

@@ rtl/bounded_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search
// A LIFO of signed words kept in a chain of shifting cells, top in cell 0.
// ----------------------------------------------------------------------------
// Flow: status, push, pop and clear pass through a report state into the result
// register, which waits for a free output slot; find first compares the key in
// every cell, then shifts match flags down the chain one cell per cycle, over
// at most DEPTH cells. A new item is accepted only once the last result is registered.
// Reset: count cleared and capacity set to 16; cell words are not cleared.
module bounded_stack_with_search
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     capacity_we_i,
  input  logic [CNT_W-1:0]         capacity_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     accepted_o,
  output logic                     found_o,
  output logic [IDX_W-1:0]         found_index_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] bottom_value_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     full_res_o,
  output logic                     empty_res_o
);

  cell_ctrl_t        cell_ctrl;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_data, next_data;
    logic              prev_valid, prev_hit, next_valid;

    if (i == 0) begin : g_head
      assign prev_data  = cell_ctrl.key;
      assign prev_valid = 1'b1;
      assign prev_hit   = 1'b0;
    end else begin : g_body
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_hit   = cell_hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    bss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .prev_hit_i   (prev_hit),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .hit_o        (cell_hit[i])
    );
  end

  bss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capacity_we_i  (capacity_we_i),
    .capacity_i     (capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .cell_ctrl_o    (cell_ctrl),
    .top_data_i     (cell_data[0]),
    .last_hit_i     (cell_hit[DEPTH-1]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .found_o        (found_o),
    .found_index_o  (found_index_o),
    .top_value_o    (top_value_o),
    .bottom_value_o (bottom_value_o),
    .count_o        (count_o),
    .full_res_o     (full_res_o),
    .empty_res_o    (empty_res_o)
  );

endmodule

@@ rtl/bss_monitor.sv @@
// ----------------------------------------------------------------------------
// Bounded stack port monitor
// Checks result consistency and output stability on the top-level ports.
// ----------------------------------------------------------------------------
module bss_monitor
  import bss_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     found_i,
  input logic [IDX_W-1:0]         found_index_i,
  input logic signed [DATA_W-1:0] top_value_i,
  input logic signed [DATA_W-1:0] bottom_value_i,
  input logic [CNT_W-1:0]         count_i,
  input logic                     empty_res_i
);

  // A result waiting for transfer keeps its values.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(top_value_i) && $stable(count_i) && $stable(found_index_i))
    else $error("result changed while stalled");

  // An empty stack reports -1 at both ends and a zero count.
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_res_i |->
      count_i == '0 && top_value_i == '1 && bottom_value_i == '1)
    else $error("empty result with wrong snapshot");

  // No match means the index reads zero.
  a_no_match_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> found_index_i == '0)
    else $error("index set without a match");

  // With one word stored, top and bottom are the same word.
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && count_i == CNT_W'(1) |-> top_value_i == bottom_value_i)
    else $error("top and bottom differ with one word");

endmodule

bind bounded_stack_with_search bss_monitor u_monitor (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .found_i        (found_o),
  .found_index_i  (found_index_o),
  .top_value_i    (top_value_o),
  .bottom_value_i (bottom_value_o),
  .count_i        (count_o),
  .empty_res_i    (empty_res_o)
);
